### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro reports through $error and is disabled while reset is high.
// Defining SYNTH turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Plain property
`define MHF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define MHF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MHF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MHF_ASSERT(lbl, clk, rst, prop, msg)
`define MHF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MHF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### hw/rtl/mhf_pkg.sv
package mhf_pkg;

  // Line buffer depth default
  localparam int DEF_MAX_WIDTH = 2048;

  // Config register fields
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int FRAME_W_W    = 12;
  localparam int FRAME_H_W    = 13;
  localparam int THRESH_W     = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_THRESHOLD = 2'd2;

  // Reset values of the config registers
  localparam logic [FRAME_W_W-1:0] RST_FRAME_WIDTH    = 12'd640;
  localparam logic [FRAME_H_W-1:0] RST_FRAME_HEIGHT   = 13'd480;
  localparam logic [THRESH_W-1:0]  RST_FILL_THRESHOLD = 3'd5;

  // Value written into a filled hole
  localparam logic [7:0] FILL_VALUE = 8'd255;

  // Line buffer word: {nonzero flag of older row, byte of newer row}
  localparam int LB_DATA_W = 9;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       flush;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       frame_end;
  } out_word_t;

  // Position flags of the item held in the compute stage
  typedef struct packed {
    logic [7:0] cur;
    logic       prev_bit;
    logic       flush_pos;
    logic       has_right;
    logic       col_pos;
    logic       row_ge1;
    logic       row_ge2;
    logic       frame_end;
  } s1_item_t;

endpackage

### hw/rtl/mhf_linebuf.sv
`include "assert_macros.svh"

// Two-row line buffer: one write port, two registered read ports.
// A read that hits the address written at the same edge returns the new word.
module mhf_linebuf import mhf_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr0,
  input  logic [AW-1:0]        rd_addr1,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [LB_DATA_W-1:0] wr_data,
  output logic [LB_DATA_W-1:0] rd_data0,
  output logic [LB_DATA_W-1:0] rd_data1
);

  logic [LB_DATA_W-1:0] mem [DEPTH];
  logic [LB_DATA_W-1:0] q0;
  logic [LB_DATA_W-1:0] q1;
  logic [LB_DATA_W-1:0] fwd_data;
  logic                 fwd0;
  logic                 fwd1;

  // Memory array, read-first
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q0 <= mem[rd_addr0];
      q1 <= mem[rd_addr1];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Bypass for a read colliding with the write of the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd0 <= 1'b0;
      fwd1 <= 1'b0;
    end else if (rd_en) begin
      fwd0 <= wr_en && (rd_addr0 == wr_addr);
      fwd1 <= wr_en && (rd_addr1 == wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en && wr_en) begin
      fwd_data <= wr_data;
    end
  end

  assign rd_data0 = fwd0 ? fwd_data : q0;
  assign rd_data1 = fwd1 ? fwd_data : q1;

  `MHF_ASSERT_NXT(a_fwd_port0, clk, rst, rd_en && wr_en && (rd_addr0 == wr_addr), rd_data0 == $past(wr_data), "port 0 missed same-edge write")
  `MHF_ASSERT_NXT(a_fwd_port1, clk, rst, rd_en && wr_en && (rd_addr1 == wr_addr), rd_data1 == $past(wr_data), "port 1 missed same-edge write")

endmodule

### hw/rtl/mask_hole_fill_3x3_top.sv
// Pixel (r, c) is decided with the word for (r+1, c) in the compute stage, then registered.
// Throughput: one word per cycle unless output stalls; two line buffer reads per kept word.
// Rows are output one row late; a row of flush words drives out the last row.
// Reset (rst, synchronous): counters, pipeline valids and config registers return to defaults;
// the line buffer is not cleared, the first row of a frame gives no results.
`include "assert_macros.svh"

module mask_hole_fill_3x3_top import mhf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > FRAME_W_W) ? WW : FRAME_W_W;

  // Config registers
  logic [FRAME_W_W-1:0] frame_width;
  logic [FRAME_H_W-1:0] frame_height;
  logic [THRESH_W-1:0]  fill_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      fill_threshold <= RST_FILL_THRESHOLD;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    frame_width    <= cfg_data[FRAME_W_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height   <= cfg_data[FRAME_H_W-1:0];
        CFG_FILL_THRESHOLD: fill_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size
  logic [CW-1:0]        w_eff;
  logic [FRAME_H_W-1:0] h_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(frame_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    h_eff = (frame_height == '0) ? FRAME_H_W'(1) : frame_height;
  end

  // Raster position of the next word
  logic [AW-1:0]        col_cnt;
  logic [FRAME_H_W-1:0] row_cnt;
  logic                 prev_bit;

  logic                 wrap_c;
  logic [FRAME_H_W:0]   row_a;
  logic                 row_wrap;
  logic [FRAME_H_W-1:0] row0;
  logic [AW-1:0]        col0;
  logic                 pb0;
  logic                 flush_pos;
  logic                 in_drop;
  logic [7:0]           cur;
  logic [CW-1:0]        col_nx;
  logic                 end_row;
  logic [FRAME_H_W:0]   row_nx;
  logic [FRAME_H_W-1:0] row_after;
  logic                 in_fire;

  always_comb begin
    wrap_c    = CW'(col_cnt) >= w_eff;
    row_a     = wrap_c ? ({1'b0, row_cnt} + (FRAME_H_W+1)'(1)) : {1'b0, row_cnt};
    row_wrap  = row_a > {1'b0, h_eff};
    row0      = row_wrap ? '0 : row_a[FRAME_H_W-1:0];
    col0      = wrap_c ? '0 : col_cnt;
    pb0       = prev_bit && !wrap_c && !row_wrap;
    flush_pos = (row0 == h_eff);
    in_drop   = !flush_pos && in_data.flush;
    cur       = flush_pos ? 8'd0 : in_data.pixel_value;
    col_nx    = CW'(col0) + CW'(1);
    end_row   = col_nx >= w_eff;
    row_nx    = {1'b0, row0} + (FRAME_H_W+1)'(1);
    row_after = (row_nx > {1'b0, h_eff}) ? '0 : row_nx[FRAME_H_W-1:0];
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      prev_bit <= 1'b0;
    end else if (in_fire) begin
      if (in_drop) begin
        col_cnt  <= col0;
        row_cnt  <= row0;
        prev_bit <= pb0;
      end else begin
        col_cnt  <= end_row ? '0 : col_nx[AW-1:0];
        row_cnt  <= end_row ? row_after : row0;
        prev_bit <= !end_row && (cur != 8'd0);
      end
    end
  end

  // Compute stage
  logic          s1_valid;
  s1_item_t      s1_item;
  logic [AW-1:0] s1_col;
  logic          s1_adv;
  logic          left_bit;
  logic          rd_en;

  logic [LB_DATA_W-1:0] lb_data0;
  logic [LB_DATA_W-1:0] lb_data1;
  logic [LB_DATA_W-1:0] lb_wr_data;

  assign s1_adv   = s1_valid && (!s1_item.row_ge1 || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign rd_en    = in_fire && !in_drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_col            <= col0;
      s1_item.cur       <= cur;
      s1_item.prev_bit  <= pb0;
      s1_item.flush_pos <= flush_pos;
      s1_item.has_right <= !end_row;
      s1_item.col_pos   <= col0 != '0;
      s1_item.row_ge1   <= row0 != '0;
      s1_item.row_ge2   <= row0 > FRAME_H_W'(1);
      s1_item.frame_end <= flush_pos && end_row;
    end
  end

  mhf_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_linebuf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr0 (col0),
    .rd_addr1 (col_nx[AW-1:0]),
    .wr_en    (s1_adv),
    .wr_addr  (s1_col),
    .wr_data  (lb_wr_data),
    .rd_data0 (lb_data0),
    .rd_data1 (lb_data1)
  );

  // Neighbour count and fill decision
  logic [7:0]          centre;
  logic                centre_bit;
  logic [2:0]          count;
  logic [7:0]          result;

  always_comb begin
    centre     = lb_data0[7:0];
    centre_bit = centre != 8'd0;
    count      = {2'b0, s1_item.row_ge2 & lb_data0[8]}
               + {2'b0, s1_item.row_ge2 & s1_item.has_right & lb_data1[8]}
               + {2'b0, s1_item.col_pos & left_bit}
               + {2'b0, s1_item.has_right & (lb_data1[7:0] != 8'd0)}
               + {2'b0, !s1_item.flush_pos & (s1_item.cur != 8'd0)}
               + {2'b0, !s1_item.flush_pos & s1_item.col_pos & s1_item.prev_bit};
    result     = (!centre_bit && (count >= fill_threshold)) ? FILL_VALUE : centre;
    lb_wr_data = {centre_bit, s1_item.cur};
  end

  // Left neighbour: older-row flag written by the previous word
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_bit <= centre_bit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_item.row_ge1) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item.row_ge1) begin
      out_data.out_value <= result;
      out_data.frame_end <= s1_item.frame_end;
    end
  end

  `MHF_ASSERT_IMP(a_ready_when_empty, clk, rst, !s1_valid, in_ready, "input stalled with empty stage")
  `MHF_ASSERT_NXT(a_stage_holds, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_col), "compute stage lost a stalled word")
  `MHF_ASSERT_NXT(a_stage_loads, clk, rst, in_fire && !in_drop, s1_valid, "accepted pixel did not reach compute stage")
  `MHF_ASSERT_IMP(a_frame_end_pos, clk, rst, s1_valid && s1_item.frame_end, s1_item.flush_pos && !s1_item.has_right && s1_item.row_ge1, "frame end off the last flush column")

endmodule

### tb/tb_mask_hole_fill_3x3_top.sv
`timescale 1ns / 1ps

module tb_mask_hole_fill_3x3_top import mhf_pkg::*; ();

  localparam int LINE_MAX    = DEF_MAX_WIDTH;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int PRINT_CAP   = 50;
  // index 3 is not decoded by the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  in_word_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  cfg_ready;
  out_word_t             out_data;

  mask_hole_fill_3x3_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Words waiting to be offered, register writes waiting, predicted output words
  in_word_t   mask_feed_q[$];
  reg_write_t reg_write_q[$];
  out_word_t  predicted_px_q[$];

  // Idling controls, set between frames
  int unsigned tx_gap_max   = 0;
  int unsigned rx_stall_max = 0;
  bit          hold_arm     = 1'b0;
  bit          hold_done    = 1'b0;

  int unsigned n_errors  = 0;
  int unsigned fed_items = 0;

  // Shadow of the block: registers, line buffers and raster position
  bit [FRAME_W_W-1:0] m_width;
  bit [FRAME_H_W-1:0] m_height;
  bit [THRESH_W-1:0]  m_thresh;
  bit                 above_nz [LINE_MAX];
  bit [7:0]           centre_px [LINE_MAX];
  bit                 left_nz;
  int unsigned        col_pos;
  int unsigned        row_pos;

  function automatic int unsigned width_eff(input bit [FRAME_W_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > LINE_MAX) return LINE_MAX;
    return raw;
  endfunction

  // Advance the shadow by one input word; returns 1 when a result word is due
  function automatic bit predict_fill(input in_word_t word, output out_word_t res);
    int unsigned w, h, col, row, cnt;
    bit          at_flush, right_ok, cur_nz;
    bit [7:0]    cur, old_c;
    w = width_eff(m_width);
    h = (m_height == 0) ? 1 : m_height;
    res = '0;
    // wrap left over from a register change
    if (col_pos >= w) begin
      col_pos = 0;
      left_nz = 1'b0;
      row_pos++;
    end
    if (row_pos > h) begin
      row_pos = 0;
      left_nz = 1'b0;
    end
    col = col_pos;
    row = row_pos;
    at_flush = (row == h);
    // flush word inside the pixel rows: dropped without trace
    if (!at_flush && word.flush) return 1'b0;
    cur = at_flush ? 8'd0 : word.pixel_value;
    cur_nz = (cur != 0);
    old_c = centre_px[col];
    right_ok = (col + 1) < w;
    if (row >= 1) begin
      res.out_value = old_c;
      if (old_c == 0) begin
        cnt = 0;
        if (row >= 2) begin
          cnt += above_nz[col];
          if (right_ok) cnt += above_nz[col + 1];
        end
        if (col > 0) cnt += above_nz[col - 1];
        if (right_ok && centre_px[col + 1] != 0) cnt++;
        if (!at_flush) begin
          cnt += cur_nz;
          if (col > 0) cnt += left_nz;
        end
        if (cnt >= m_thresh) res.out_value = FILL_VALUE;
      end
      res.frame_end = at_flush && (col == w - 1);
    end
    above_nz[col] = (old_c != 0);
    centre_px[col] = cur;
    left_nz = cur_nz;
    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      left_nz = 1'b0;
      row_pos = row + 1;
      if (row_pos > h) row_pos = 0;
    end
    return row >= 1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    n_errors++;
  endtask

  // Pixel driver: one word at a time, random gap after each
  int unsigned tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (mask_feed_q.size() != 0) begin
        in_data  <= mask_feed_q.pop_front();
        in_valid <= 1'b1;
        tx_gap = $urandom_range(0, tx_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Register write driver
  always @(posedge clk) begin
    reg_write_t wr;
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if ((!cfg_valid || cfg_ready) && reg_write_q.size() != 0) begin
      wr = reg_write_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.idx;
      cfg_data  <= wr.data;
    end else if (cfg_ready) begin
      cfg_valid <= 1'b0;
    end
  end

  // Monitor: shadow update on accepted words, then check of the output word
  int unsigned rx_gap   = 0;
  int unsigned rx_hold  = 0;
  int unsigned rx_count = 0;
  always @(posedge clk) begin
    out_word_t due, want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap = 0;
      rx_hold = 0;
      m_width = RST_FRAME_WIDTH;
      m_height = RST_FRAME_HEIGHT;
      m_thresh = RST_FILL_THRESHOLD;
      left_nz = 1'b0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:    m_width  = cfg_data[FRAME_W_W-1:0];
          CFG_FRAME_HEIGHT:   m_height = cfg_data[FRAME_H_W-1:0];
          CFG_FILL_THRESHOLD: m_thresh = cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (predict_fill(in_data, due)) predicted_px_q = {predicted_px_q, due};
      end
      if (out_valid && out_ready) begin
        rx_count++;
        if (predicted_px_q.size() == 0) begin
          report_mismatch($sformatf("output word %h with nothing expected", out_data));
        end else begin
          want = predicted_px_q.pop_front();
          if (out_data.out_value !== want.out_value)
            report_mismatch($sformatf("out_value got %0d want %0d",
                                      out_data.out_value, want.out_value));
          if (out_data.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end got %b want %b",
                                      out_data.frame_end, want.frame_end));
        end
        rx_gap = $urandom_range(0, rx_stall_max);
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      // one long back-pressure stretch so the block fills and stalls its input
      if (hold_arm && !hold_done && rx_count >= 8) begin
        rx_hold = LONG_HOLD;
        hold_done = 1'b1;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_ready <= (rx_gap == 0) && (rx_hold == 0);
    end
  end

  // Watchdog: too long without any handshake
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register values as last programmed
  bit [FRAME_W_W-1:0] plan_w = RST_FRAME_WIDTH;
  bit [FRAME_H_W-1:0] plan_h = RST_FRAME_HEIGHT;
  bit [THRESH_W-1:0]  plan_t = RST_FILL_THRESHOLD;

  task automatic push_word(input bit flush, input bit [7:0] px);
    in_word_t word;
    word.flush = flush;
    word.pixel_value = px;
    mask_feed_q = {mask_feed_q, word};
    fed_items++;
  endtask

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    reg_write_t wr;
    wr.idx = idx;
    wr.data = data;
    reg_write_q = {reg_write_q, wr};
  endtask

  function automatic bit [7:0] mask_byte(input int unsigned density);
    if ($urandom_range(0, 99) >= density) return 8'd0;
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : FILL_VALUE;
  endfunction

  // Block idle only: changed registers always written, others now and then
  task automatic program_regs(input bit [FRAME_W_W-1:0] w, input bit [FRAME_H_W-1:0] h,
                              input bit [THRESH_W-1:0] t);
    if (w != plan_w || $urandom_range(0, 2) == 0)
      queue_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    if (h != plan_h || $urandom_range(0, 2) == 0)
      queue_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    if ($urandom_range(0, 7) == 0)
      queue_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    if (t != plan_t || $urandom_range(0, 2) == 0)
      queue_reg(CFG_FILL_THRESHOLD, CFG_DATA_W'(t));
    plan_w = w;
    plan_h = h;
    plan_t = t;
    while (reg_write_q.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  // Wait for every word taken and every result back, then the pipeline latency
  task automatic drain();
    while (mask_feed_q.size() != 0 || in_valid || predicted_px_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One frame of random mask content followed by its flush row
  task automatic feed_frame(input bit [FRAME_W_W-1:0] w_raw, input bit [FRAME_H_W-1:0] h_raw,
                            input bit [THRESH_W-1:0] thr, input int unsigned density,
                            input int unsigned noise_pct);
    int unsigned w, h;
    program_regs(w_raw, h_raw, thr);
    w = width_eff(w_raw);
    h = (h_raw == 0) ? 1 : h_raw;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(0, 99) < noise_pct) push_word(1'b1, 8'($urandom));
        push_word(1'b0, mask_byte(density));
      end
    end
    // flush row: any word here counts as flush
    for (int c = 0; c < w; c++) push_word($urandom_range(0, 3) != 0, 8'($urandom));
    drain();
  endtask

  initial begin
    bit [7:0]           hole_px [15];
    bit [FRAME_W_W-1:0] w;
    bit [FRAME_H_W-1:0] h;
    int unsigned        density;

    hole_px = '{8'd0,   8'd255, 8'd0,   8'd1,   8'd128,
                8'd255, 8'd0,   8'd255, 8'd0,   8'd0,
                8'd0,   8'd7,   8'd0,   8'd255, 8'd64};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: 5x3 frame, threshold zero fills every hole; stray flush words
    tx_gap_max = 3;
    rx_stall_max = 3;
    program_regs(12'd5, 13'd3, 3'd0);
    push_word(1'b1, 8'hFF);
    for (int i = 0; i < 15; i++) begin
      if (i == 7) push_word(1'b1, 8'h5A);
      push_word(1'b0, hole_px[i]);
    end
    push_word(1'b1, 8'h00);
    push_word(1'b1, 8'hFF);
    push_word(1'b0, 8'hAA);
    push_word(1'b1, 8'h00);
    push_word(1'b1, 8'h01);
    drain();

    // Directed: zero width and height act as 1, threshold above six never fills
    program_regs(12'd0, 13'd0, 3'd7);
    push_word(1'b0, 8'd0);
    push_word(1'b0, 8'd255);
    drain();

    // Back-pressure frame: sender never idles while the receiver holds off
    tx_gap_max = 0;
    rx_stall_max = 0;
    hold_arm = 1'b1;
    feed_frame(12'd12, 13'd8, 3'd4, 50, 0);

    // Random frames, mostly small
    while (fed_items < 430) begin
      case ($urandom_range(0, 9))
        0:       w = 12'd0;
        1:       w = 12'($urandom_range(13, 48));
        default: w = 12'($urandom_range(1, 12));
      endcase
      if (w > 12) h = 13'($urandom_range(1, 3));
      else if ($urandom_range(0, 9) == 0) h = 13'd0;
      else h = 13'($urandom_range(1, 8));
      case ($urandom_range(0, 5))
        0:       density = 0;
        1:       density = 100;
        default: density = $urandom_range(20, 90);
      endcase
      case ($urandom_range(0, 2))
        0:       tx_gap_max = 0;
        1:       tx_gap_max = 3;
        default: tx_gap_max = 11;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_stall_max = 0;
        1:       rx_stall_max = 3;
        default: rx_stall_max = 11;
      endcase
      feed_frame(w, h, 3'($urandom_range(0, 7)), density, $urandom_range(0, 10));
    end

    // Catch any stray output words
    repeat (20) @(negedge clk);
    if (n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mhf_pkg.sv
hw/rtl/mhf_linebuf.sv
hw/rtl/mask_hole_fill_3x3_top.sv
tb/tb_mask_hole_fill_3x3_top.sv
